@@ hdl/vsce_pkg.sv @@
package vsce_pkg;

  // Field types of the input and result items.
  typedef logic [5:0]  face_t;
  typedef logic [7:0]  color_t;
  typedef logic [63:0] word_t;
  typedef logic [3:0]  bcnt_t;
  typedef logic [9:0]  colbytes_t;

  // Bytes in one packed result word.
  localparam bcnt_t WORD_BYTES = 4'd8;

  // Saturation value of the per-column byte total.
  localparam colbytes_t COL_BYTES_MAX = 10'd1023;

endpackage

@@ hdl/voxel_slab_column_encoder_core.sv @@
// An item is checked, written into the slab state and finished; each slab it closes flushes three header
// bytes and one byte per color, and a stalling result side holds the flush.
// Throughput: one item at a time; the byte packer and the color store read port
// move one byte per cycle while the result side takes full words without a stall.
// Reset: synchronous active-low rst_n clears depth, slab state, column total and the
// handshake; the color store is not cleared and is only read where it was written.
module voxel_slab_column_encoder_core #(
  parameter int MAX_HEIGHT  = 255,
  parameter int STORE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  vsce_pkg::face_t     in_face_mask,
  input  vsce_pkg::color_t    in_color_index,
  input  logic                in_column_end,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output vsce_pkg::word_t     out_packed_bytes,
  output vsce_pkg::bcnt_t     out_byte_count,
  output logic                out_column_done,
  output vsce_pkg::colbytes_t out_column_bytes,
  output logic                out_last_of_run
);
  import vsce_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [7:0] MaxH = 8'(MAX_HEIGHT);
  localparam logic [7:0] CapLen = 8'((STORE_DEPTH < 255) ? STORE_DEPTH : 255);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TOP,
    S_LEN,
    S_FACES,
    S_COLOR,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t     state_r;
  face_t      fm_r;
  color_t     col_r;
  logic       end_r;
  logic       vis_r;
  logic       second_r;
  logic [7:0] depth_r;
  logic       open_r;
  logic [7:0] top_r;
  logic [7:0] len_r;
  face_t      faces_r;
  colbytes_t  total_r;
  word_t      acc_r;
  bcnt_t      acc_cnt_r;
  logic [7:0] k_r;
  color_t     rd_data_r;

  word_t      out_bytes_r;
  bcnt_t      out_cnt_r;
  logic       out_valid_r;
  logic       out_done_r;
  colbytes_t  out_colbytes_r;
  logic       out_last_r;

  color_t     color_mem [STORE_DEPTH];

  logic          z_ok;
  logic          vis;
  logic          cont;
  logic          flush_a;
  logic          out_free;
  logic          emit_state;
  logic          put_ok;
  logic          acc_full;
  logic          out_load;
  logic [7:0]    k_nxt;
  logic          last_color;
  color_t        cur_byte;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // Slab decisions for the voxel at the current depth.
  assign z_ok    = depth_r < MaxH;
  assign vis     = z_ok && (fm_r != '0);
  assign cont    = ({1'b0, top_r} + {1'b0, len_r}) == {1'b0, depth_r};
  assign flush_a = vis && open_r && (!cont || (len_r >= CapLen));

  // The byte packer moves one byte a cycle; a full word must first leave for the output.
  assign out_free   = !out_valid_r || !out_stall;
  assign emit_state = (state_r == S_TOP) || (state_r == S_LEN) ||
                      (state_r == S_FACES) || (state_r == S_COLOR);
  assign acc_full   = (acc_cnt_r == WORD_BYTES);
  assign put_ok     = emit_state && (!acc_full || out_free);
  assign k_nxt      = k_r + 8'd1;
  assign last_color = (k_nxt == len_r);

  // A word enters the output register when the packer is full or the item ends.
  assign out_load = (put_ok && acc_full) ||
                    ((state_r == S_FINISH) && ((acc_cnt_r != '0) || end_r) && out_free);

  // Byte selected for the slab stream.
  always_comb begin
    unique case (state_r)
      S_TOP:   cur_byte = top_r;
      S_LEN:   cur_byte = len_r;
      S_FACES: cur_byte = {2'b00, faces_r};
      default: cur_byte = rd_data_r;
    endcase
  end

  // Color store ports: prefetch the next color while the current byte is packed.
  assign rd_en   = put_ok && ((state_r == S_FACES) || ((state_r == S_COLOR) && !last_color));
  assign rd_addr = (state_r == S_FACES) ? '0 : k_nxt[AW-1:0];
  assign wr_en   = (state_r == S_WRITE) && vis_r;
  assign wr_addr = open_r ? len_r[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      color_mem[wr_addr] <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= color_mem[rd_addr];
    end
  end

  // Sequencer, slab state, byte packer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      open_r      <= 1'b0;
      top_r       <= '0;
      len_r       <= '0;
      faces_r     <= '0;
      total_r     <= '0;
      acc_r       <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
      vis_r       <= 1'b0;
      k_r         <= '0;
    end else begin
      // The output register loads a word or empties once the receiver takes it.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // Common byte push for all stream states.
      if (put_ok) begin
        if (acc_full) begin
          out_bytes_r    <= acc_r;
          out_cnt_r      <= acc_cnt_r;
          out_done_r     <= 1'b0;
          out_colbytes_r <= '0;
          out_last_r     <= 1'b0;
          acc_r          <= {56'd0, cur_byte};
          acc_cnt_r      <= 4'd1;
        end else begin
          acc_r[{acc_cnt_r[2:0], 3'b000} +: 8] <= cur_byte;
          acc_cnt_r <= acc_cnt_r + 4'd1;
        end
        if (total_r != COL_BYTES_MAX) begin
          total_r <= total_r + 10'd1;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            fm_r    <= in_face_mask;
            col_r   <= in_color_index;
            end_r   <= in_column_end;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          vis_r <= vis;
          if (flush_a) begin
            second_r <= 1'b0;
            state_r  <= S_TOP;
          end else begin
            state_r <= S_WRITE;
          end
        end
        S_TOP: begin
          k_r <= '0;
          if (put_ok) begin
            state_r <= S_LEN;
          end
        end
        S_LEN: begin
          if (put_ok) begin
            state_r <= S_FACES;
          end
        end
        S_FACES: begin
          if (put_ok) begin
            state_r <= S_COLOR;
          end
        end
        S_COLOR: begin
          if (put_ok) begin
            if (last_color) begin
              open_r  <= 1'b0;
              state_r <= second_r ? S_FINISH : S_WRITE;
            end else begin
              k_r <= k_nxt;
            end
          end
        end
        S_WRITE: begin
          // Append the voxel to the open slab, or open a new one at this depth.
          if (vis_r) begin
            len_r   <= open_r ? (len_r + 8'd1) : 8'd1;
            faces_r <= (open_r ? faces_r : '0) | fm_r;
            if (!open_r) begin
              top_r <= depth_r;
            end
            open_r <= 1'b1;
          end
          if (z_ok) begin
            depth_r <= depth_r + 8'd1;
          end
          if (end_r && (open_r || vis_r)) begin
            second_r <= 1'b1;
            state_r  <= S_TOP;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Send the last partial word; a column end always sends one.
          if ((acc_cnt_r != '0) || end_r) begin
            if (out_free) begin
              out_bytes_r    <= acc_r;
              out_cnt_r      <= acc_cnt_r;
              out_done_r     <= end_r;
              out_colbytes_r <= end_r ? total_r : '0;
              out_last_r     <= 1'b1;
              acc_r          <= '0;
              acc_cnt_r      <= '0;
              if (end_r) begin
                total_r <= '0;
                depth_r <= '0;
                top_r   <= '0;
                len_r   <= '0;
                faces_r <= '0;
              end
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_packed_bytes = out_bytes_r;
  assign out_byte_count   = out_cnt_r;
  assign out_column_done  = out_done_r;
  assign out_column_bytes = out_colbytes_r;
  assign out_last_of_run  = out_last_r;

  // A column report only rides on the final result of an item.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_column_done) |-> out_last_of_run)
    else $error("column_done without last_of_run");

  // Every result but the last of an item carries a full word.
  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> (out_byte_count == WORD_BYTES))
    else $error("partial word before the end of an item");

  // A slab never grows past the store capacity.
  a_slab_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CapLen)
    else $error("slab length beyond capacity");

  // The packer never holds more than one word.
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_cnt_r <= WORD_BYTES)
    else $error("byte packer overflow");

endmodule
